// ----- hdl/sialu_pkg.sv -----
// ----------------------------------------------------------------------------
// Signed integer ALU package
// Opcodes, the control word that travels beside the data, and shared sizes.
// ----------------------------------------------------------------------------
package sialu_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 4;
	localparam int FRAC_W    = 5;
	localparam int SHAMT_W   = 5;

	localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd8;

	// Decimal base used by the times ten and divide by ten operations.
	localparam int DEC_BASE = 10;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_NEG   = 4'd2,
		OP_MIN   = 4'd3,
		OP_MAX   = 4'd4,
		OP_EQ    = 4'd5,
		OP_GE    = 4'd6,
		OP_MUL   = 4'd7,
		OP_DIV   = 4'd8,
		OP_SHL   = 4'd9,
		OP_SHR   = 4'd10,
		OP_X10   = 4'd11,
		OP_DIV10 = 4'd12,
		OP_FXMUL = 4'd13,
		OP_FXDIV = 4'd14,
		OP_NONE  = 4'd15
	} op_t;

	// Control word carried along the pipeline with every operation.
	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [FRAC_W-1:0] frac;
		logic              neg;     // sign to reapply to the chain result
		logic              direct;  // result already settled before the chain
	} ctrl_t;

endpackage

// ----- hdl/sialu_front.sv -----
// ----------------------------------------------------------------------------
// Signed integer ALU front end
// Captures the operation, settles the simple operations and the shifts, and
// prepares magnitudes and signs for the multiply and divide cell chain.
// ----------------------------------------------------------------------------
module sialu_front #(
	parameter int WIDTH = sialu_pkg::WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 take,
	input  logic [sialu_pkg::OP_W-1:0]           op_in,
	input  logic signed [sialu_pkg::DATA_W-1:0]  a_in,
	input  logic signed [sialu_pkg::DATA_W-1:0]  b_in,
	input  logic [sialu_pkg::SHAMT_W-1:0]        shamt_in,
	input  logic [sialu_pkg::FRAC_W-1:0]         frac_in,
	output sialu_pkg::ctrl_t                     ctrl_o,
	output logic [sialu_pkg::DATA_W-1:0]         dres_o,
	output logic [WIDTH-1:0]                     mc_o,
	output logic [WIDTH-1:0]                     mplier_o,
	output logic [WIDTH-1:0]                     dvd_o,
	output logic [WIDTH-1:0]                     dvs_o
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	sialu_pkg::op_t                  op_s1, op_s2, op_s3, op_s4;
	logic [WIDTH-1:0]                a_s1, b_s1;
	logic [sialu_pkg::SHAMT_W-1:0]   sh_s1;
	logic [sialu_pkg::FRAC_W-1:0]    f_s1, f_s2, f_s3, f_s4;

	logic [sialu_pkg::DATA_W-1:0]    simple_s2, simple_s3;
	logic [WIDTH-1:0]                mag_a_s2, mag_a_s3, mag_a_s4;
	logic [WIDTH-1:0]                mag_b_s2, mag_b_s3, mag_b_s4;
	logic                            neg_a_s2, neg_a_s3, neg_a_s4;
	logic                            neg_b_s2, neg_b_s3, neg_b_s4;
	logic [sialu_pkg::SHAMT_W-1:0]   sh_s2;
	logic [WIDTH-1:0]                shl_s3, shr_s3;
	logic [WIDTH-1:0]                x_s4;
	logic [sialu_pkg::DATA_W-1:0]    dres_s4;

	sialu_pkg::ctrl_t                ctrl_s5;
	logic [sialu_pkg::DATA_W-1:0]    dres_s5;
	logic [WIDTH-1:0]                mc_s5, mplier_s5, dvd_s5, dvs_s5;

	logic                            ge_c;
	logic [WIDTH-1:0]                simple_c;
	logic [WIDTH-1:0]                shl_neg_c, shr_neg_c;
	logic [WIDTH-1:0]                mag_x_c;
	logic                            neg_x_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: capture, operands sign-extended to the working width.
	always_ff @(posedge clk) begin
		op_s1 <= sialu_pkg::op_t'(op_in);
		a_s1  <= WIDTH'(a_in);
		b_s1  <= WIDTH'(b_in);
		sh_s1 <= shamt_in;
		f_s1  <= frac_in;
	end

	// Signed greater-or-equal: differing signs decide, else unsigned order.
	always_comb begin
		if (a_s1[WIDTH-1] != b_s1[WIDTH-1]) begin
			ge_c = b_s1[WIDTH-1];
		end else begin
			ge_c = (a_s1 >= b_s1);
		end
		unique case (op_s1)
			sialu_pkg::OP_ADD: simple_c = a_s1 + b_s1;
			sialu_pkg::OP_SUB: simple_c = a_s1 - b_s1;
			sialu_pkg::OP_NEG: simple_c = ~a_s1 + WIDTH'(1);
			sialu_pkg::OP_MIN: simple_c = ge_c ? b_s1 : a_s1;
			sialu_pkg::OP_MAX: simple_c = ge_c ? a_s1 : b_s1;
			sialu_pkg::OP_EQ:  simple_c = WIDTH'(a_s1 == b_s1);
			sialu_pkg::OP_GE:  simple_c = WIDTH'(ge_c);
			default:           simple_c = '0;
		endcase
	end

	// Stage 2: simple results, magnitudes and signs.
	always_ff @(posedge clk) begin
		op_s2     <= op_s1;
		f_s2      <= f_s1;
		simple_s2 <= simple_c[sialu_pkg::DATA_W-1:0];
		neg_a_s2  <= a_s1[WIDTH-1];
		neg_b_s2  <= b_s1[WIDTH-1];
		mag_a_s2  <= a_s1[WIDTH-1] ? (~a_s1 + WIDTH'(1)) : a_s1;
		mag_b_s2  <= b_s1[WIDTH-1] ? (~b_s1 + WIDTH'(1)) : b_s1;
		sh_s2     <= (op_s1 == sialu_pkg::OP_FXDIV) ? f_s1 : sh_s1;
	end

	// Stage 3: magnitude shifts.
	always_ff @(posedge clk) begin
		op_s3     <= op_s2;
		f_s3      <= f_s2;
		simple_s3 <= simple_s2;
		neg_a_s3  <= neg_a_s2;
		neg_b_s3  <= neg_b_s2;
		mag_a_s3  <= mag_a_s2;
		mag_b_s3  <= mag_b_s2;
		shl_s3    <= mag_a_s2 << sh_s2;
		shr_s3    <= mag_a_s2 >> sh_s2;
	end

	assign shl_neg_c = neg_a_s3 ? (~shl_s3 + WIDTH'(1)) : shl_s3;
	assign shr_neg_c = neg_a_s3 ? (~shr_s3 + WIDTH'(1)) : shr_s3;

	// Stage 4: sign reapplied to the shifted magnitudes.
	always_ff @(posedge clk) begin
		op_s4    <= op_s3;
		f_s4     <= f_s3;
		neg_a_s4 <= neg_a_s3;
		neg_b_s4 <= neg_b_s3;
		mag_a_s4 <= mag_a_s3;
		mag_b_s4 <= mag_b_s3;
		x_s4     <= shl_neg_c;
		unique case (op_s3)
			sialu_pkg::OP_SHL: dres_s4 <= shl_neg_c[sialu_pkg::DATA_W-1:0];
			sialu_pkg::OP_SHR: dres_s4 <= shr_neg_c[sialu_pkg::DATA_W-1:0];
			default:           dres_s4 <= simple_s3;
		endcase
	end

	// The fixed-point dividend is the signed shifted word, so take its
	// magnitude afresh.
	assign neg_x_c = x_s4[WIDTH-1];
	assign mag_x_c = neg_x_c ? (~x_s4 + WIDTH'(1)) : x_s4;

	// Stage 5: operands for the cell chain.
	always_ff @(posedge clk) begin
		ctrl_s5.valid  <= v_s4;
		ctrl_s5.op     <= op_s4;
		ctrl_s5.frac   <= f_s4;
		dres_s5        <= dres_s4;
		mc_s5          <= mag_a_s4;
		mplier_s5      <= (op_s4 == sialu_pkg::OP_X10) ? WIDTH'(sialu_pkg::DEC_BASE) : mag_b_s4;
		dvd_s5         <= (op_s4 == sialu_pkg::OP_FXDIV) ? mag_x_c : mag_a_s4;
		dvs_s5         <= (op_s4 == sialu_pkg::OP_DIV10) ? WIDTH'(sialu_pkg::DEC_BASE) : mag_b_s4;
		unique case (op_s4)
			sialu_pkg::OP_MUL, sialu_pkg::OP_DIV, sialu_pkg::OP_FXMUL: begin
				ctrl_s5.neg    <= neg_a_s4 ^ neg_b_s4;
				ctrl_s5.direct <= 1'b0;
			end
			sialu_pkg::OP_X10, sialu_pkg::OP_DIV10: begin
				ctrl_s5.neg    <= neg_a_s4;
				ctrl_s5.direct <= 1'b0;
			end
			sialu_pkg::OP_FXDIV: begin
				ctrl_s5.neg    <= neg_x_c ^ neg_b_s4;
				ctrl_s5.direct <= 1'b0;
			end
			default: begin
				ctrl_s5.neg    <= 1'b0;
				ctrl_s5.direct <= 1'b1;
			end
		endcase
	end

	always_comb begin
		ctrl_o       = ctrl_s5;
		ctrl_o.valid = v_s5;
	end

	assign dres_o   = dres_s5;
	assign mc_o     = mc_s5;
	assign mplier_o = mplier_s5;
	assign dvd_o    = dvd_s5;
	assign dvs_o    = dvs_s5;

endmodule

// ----- hdl/sialu_cell.sv -----
// ----------------------------------------------------------------------------
// Signed integer ALU chain cell
// One shift-add multiply step and one restoring divide step per cell.
// ----------------------------------------------------------------------------
module sialu_cell #(
	parameter int WIDTH = sialu_pkg::WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sialu_pkg::ctrl_t              ctrl_i,
	input  logic [sialu_pkg::DATA_W-1:0]  dres_i,
	input  logic [WIDTH-1:0]              acc_i,
	input  logic [WIDTH-1:0]              mc_i,
	input  logic [WIDTH-1:0]              mplier_i,
	input  logic [WIDTH-1:0]              rem_i,
	input  logic [WIDTH-1:0]              dvd_i,
	input  logic [WIDTH-1:0]              dvs_i,
	output sialu_pkg::ctrl_t              ctrl_o,
	output logic [sialu_pkg::DATA_W-1:0]  dres_o,
	output logic [WIDTH-1:0]              acc_o,
	output logic [WIDTH-1:0]              mc_o,
	output logic [WIDTH-1:0]              mplier_o,
	output logic [WIDTH-1:0]              rem_o,
	output logic [WIDTH-1:0]              dvd_o,
	output logic [WIDTH-1:0]              dvs_o
);

	logic                          valid_q;
	sialu_pkg::ctrl_t              ctrl_q;
	logic [sialu_pkg::DATA_W-1:0]  dres_q;
	logic [WIDTH-1:0]              acc_q, mc_q, mplier_q, rem_q, dvd_q, dvs_q;

	logic [WIDTH:0]                rem_sh, trial;
	logic                          qbit;

	// Bring down the next dividend bit and try the subtraction; a zero
	// divisor always succeeds, which yields an all-ones quotient.
	assign rem_sh = {rem_i, dvd_i[WIDTH-1]};
	assign trial  = rem_sh - {1'b0, dvs_i};
	assign qbit   = !trial[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctrl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_q   <= ctrl_i;
		dres_q   <= dres_i;
		acc_q    <= acc_i + (mplier_i[0] ? mc_i : '0);
		mc_q     <= mc_i << 1;
		mplier_q <= mplier_i >> 1;
		rem_q    <= qbit ? trial[WIDTH-1:0] : rem_sh[WIDTH-1:0];
		dvd_q    <= {dvd_i[WIDTH-2:0], qbit};
		dvs_q    <= dvs_i;
	end

	always_comb begin
		ctrl_o       = ctrl_q;
		ctrl_o.valid = valid_q;
	end

	assign dres_o   = dres_q;
	assign acc_o    = acc_q;
	assign mc_o     = mc_q;
	assign mplier_o = mplier_q;
	assign rem_o    = rem_q;
	assign dvd_o    = dvd_q;
	assign dvs_o    = dvs_q;

endmodule

// ----- hdl/sialu_post.sv -----
// ----------------------------------------------------------------------------
// Signed integer ALU back end
// Reapplies signs to chain results, performs the fixed-point rescale and
// registers the final word.
// ----------------------------------------------------------------------------
module sialu_post #(
	parameter int WIDTH = sialu_pkg::WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sialu_pkg::ctrl_t                     ctrl_i,
	input  logic [sialu_pkg::DATA_W-1:0]         dres_i,
	input  logic [WIDTH-1:0]                     prod_i,
	input  logic [WIDTH-1:0]                     quot_i,
	output logic                                 done_o,
	output logic signed [sialu_pkg::DATA_W-1:0]  result_o
);

	logic v_s1, v_s2, v_s3, done_q;

	sialu_pkg::op_t                 op_s1, op_s2, op_s3;
	logic [sialu_pkg::FRAC_W-1:0]   f_s1, f_s2;
	logic                           direct_s1, direct_s2, direct_s3;
	logic [sialu_pkg::DATA_W-1:0]   dres_s1, dres_s2, dres_s3;
	logic [WIDTH-1:0]               val_s1;
	logic [sialu_pkg::DATA_W-1:0]   val_s2, val_s3;
	logic [WIDTH-1:0]               mag_s2, sh_s3;
	logic                           neg_s2, neg_s3;
	logic [WIDTH-1:0]               base_c, fx_c;
	logic [sialu_pkg::DATA_W-1:0]   result_q;

	always_comb begin
		unique case (ctrl_i.op)
			sialu_pkg::OP_MUL, sialu_pkg::OP_X10, sialu_pkg::OP_FXMUL: base_c = prod_i;
			default:                                                   base_c = quot_i;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= ctrl_i.valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= ctrl_i.op;
		f_s1      <= ctrl_i.frac;
		direct_s1 <= ctrl_i.direct;
		dres_s1   <= dres_i;
		val_s1    <= ctrl_i.neg ? (~base_c + WIDTH'(1)) : base_c;

		// Fixed-point multiply rescales the signed product by magnitude.
		op_s2     <= op_s1;
		f_s2      <= f_s1;
		direct_s2 <= direct_s1;
		dres_s2   <= dres_s1;
		val_s2    <= val_s1[sialu_pkg::DATA_W-1:0];
		neg_s2    <= val_s1[WIDTH-1];
		mag_s2    <= val_s1[WIDTH-1] ? (~val_s1 + WIDTH'(1)) : val_s1;

		op_s3     <= op_s2;
		direct_s3 <= direct_s2;
		dres_s3   <= dres_s2;
		val_s3    <= val_s2;
		neg_s3    <= neg_s2;
		sh_s3     <= mag_s2 >> f_s2;
	end

	assign fx_c = neg_s3 ? (~sh_s3 + WIDTH'(1)) : sh_s3;

	always_ff @(posedge clk) begin
		if (direct_s3) begin
			result_q <= dres_s3;
		end else if (op_s3 == sialu_pkg::OP_FXMUL) begin
			result_q <= fx_c[sialu_pkg::DATA_W-1:0];
		end else begin
			result_q <= val_s3;
		end
	end

	assign done_o   = done_q;
	assign result_o = result_q;

endmodule

// ----- hdl/signed_integer_alu.sv -----
// ----------------------------------------------------------------------------
// Signed integer ALU
// Pipelined signed arithmetic unit: add, subtract, negate, min, max, compare,
// multiply, divide, magnitude shifts, decimal scaling and fixed-point
// multiply and divide, built around a chain of multiply/divide cells.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                          Handshake
//  -------   ---------------------------------------------  --------------------
//  request   op, operand_a, operand_b, shift_amount         start high, busy low
//  result    result                                         done, one cycle
//  config    frac_bits_we, frac_bits                        frac_bits_we high
//
// A new word is taken in every cycle; busy never rises, since nothing is
// shared between words in flight. Each word passes in turn through five
// front-end stages, one cell per quotient bit in the multiply/divide chain,
// and four back-end stages. The receiver cannot stall the result; done
// marks each result for exactly one cycle, in request order. Reset clears
// the valid flags along the pipeline and sets frac_bits to 8.
//
module signed_integer_alu #(
	parameter int WIDTH = sialu_pkg::WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [sialu_pkg::OP_W-1:0]           op,
	input  logic signed [sialu_pkg::DATA_W-1:0]  operand_a,
	input  logic signed [sialu_pkg::DATA_W-1:0]  operand_b,
	input  logic [sialu_pkg::SHAMT_W-1:0]        shift_amount,
	input  logic                                 frac_bits_we,
	input  logic [sialu_pkg::FRAC_W-1:0]         frac_bits,
	output logic                                 done,
	output logic signed [sialu_pkg::DATA_W-1:0]  result
);

	// The fraction-bit register is sampled into each word as it enters, so
	// a word in flight is unaffected by a later write.
	logic [sialu_pkg::FRAC_W-1:0] frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= sialu_pkg::FRAC_RESET;
		end else if (frac_bits_we) begin
			frac_q <= frac_bits;
		end
	end

	// Every cycle can take a word.
	assign busy = 1'b0;

	// Chain signals: index k feeds cell k, index WIDTH is the chain output.
	sialu_pkg::ctrl_t             ctrl_c   [0:WIDTH];
	logic [sialu_pkg::DATA_W-1:0] dres_c   [0:WIDTH];
	logic [WIDTH-1:0]             acc_c    [0:WIDTH];
	logic [WIDTH-1:0]             mc_c     [0:WIDTH];
	logic [WIDTH-1:0]             mplier_c [0:WIDTH];
	logic [WIDTH-1:0]             rem_c    [0:WIDTH];
	logic [WIDTH-1:0]             dvd_c    [0:WIDTH];
	logic [WIDTH-1:0]             dvs_c    [0:WIDTH];

	sialu_front #(
		.WIDTH(WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (start && !busy),
		.op_in    (op),
		.a_in     (operand_a),
		.b_in     (operand_b),
		.shamt_in (shift_amount),
		.frac_in  (frac_q),
		.ctrl_o   (ctrl_c[0]),
		.dres_o   (dres_c[0]),
		.mc_o     (mc_c[0]),
		.mplier_o (mplier_c[0]),
		.dvd_o    (dvd_c[0]),
		.dvs_o    (dvs_c[0])
	);

	// Product accumulator and partial remainder start from zero.
	assign acc_c[0] = '0;
	assign rem_c[0] = '0;

	// Cell k adds multiplicand times multiplier bit k and produces quotient
	// bit WIDTH-1-k; the dividend register fills with quotient bits as it
	// empties, so it holds the quotient at the end of the chain.
	for (genvar k = 0; k < WIDTH; k++) begin : g_cell
		sialu_cell #(
			.WIDTH(WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl_i   (ctrl_c[k]),
			.dres_i   (dres_c[k]),
			.acc_i    (acc_c[k]),
			.mc_i     (mc_c[k]),
			.mplier_i (mplier_c[k]),
			.rem_i    (rem_c[k]),
			.dvd_i    (dvd_c[k]),
			.dvs_i    (dvs_c[k]),
			.ctrl_o   (ctrl_c[k+1]),
			.dres_o   (dres_c[k+1]),
			.acc_o    (acc_c[k+1]),
			.mc_o     (mc_c[k+1]),
			.mplier_o (mplier_c[k+1]),
			.rem_o    (rem_c[k+1]),
			.dvd_o    (dvd_c[k+1]),
			.dvs_o    (dvs_c[k+1])
		);
	end

	sialu_post #(
		.WIDTH(WIDTH)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_i   (ctrl_c[WIDTH]),
		.dres_i   (dres_c[WIDTH]),
		.prod_i   (acc_c[WIDTH]),
		.quot_i   (dvd_c[WIDTH]),
		.done_o   (done),
		.result_o (result)
	);

endmodule
